// ===== sv/oaht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants of the open addressing hash table
// Sizes of the slot store, codes of operations, results, slot and core states,
// and the control groups between the core and its modulo unit.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = SLOT_W + 1;
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;

  // Modulo unit: dividend padded to a multiple of the bits retired per cycle
  localparam int MOD_BITS    = 4;
  localparam int MOD_DIV_W   = 32;
  localparam int MOD_CYCLES  = MOD_DIV_W / MOD_BITS;
  localparam int MOD_CNT_W   = $clog2(MOD_CYCLES);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_USED = 2'd1,
    SLOT_GONE = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

// ===== sv/oaht_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_mod: iterative key modulo table size
// Restoring remainder, MOD_BITS dividend bits per cycle, done pulses with the
// remainder once all bits are retired. A new start restarts the unit.
// ----------------------------------------------------------------------------
module oaht_mod import oaht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  logic [MOD_DIV_W-1:0] quo;
  logic [SIZE_W-1:0]    div;
  logic [SLOT_W-1:0]    rem;
  logic [SLOT_W-1:0]    rem_next;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  // Retire the top dividend bits: shift each in, subtract when it fits
  always_comb begin
    logic [SLOT_W:0] t;
    rem_next = rem;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {rem_next, quo[MOD_DIV_W-1-i]};
      if (t >= div) begin
        t = t - div;
      end
      rem_next = t[SLOT_W-1:0];
    end
  end

  // Advance the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold operands and the partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= MOD_DIV_W'(req.dividend);
      div <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= quo << MOD_BITS;
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== sv/open_addressing_hash_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core: hash table with linear probing
// Insert, search and remove on a slot store held in two synchronous memories.
// ----------------------------------------------------------------------------
// After reset the core sweeps the slot state memory to free, one slot a cycle;
// requests stall during the sweep while configuration writes are taken. An
// operation is then accepted in ST_IDLE, waits in ST_HASH while the iterative
// modulo unit finds the home slot (eight steps and then its done pulse), walks
// the chain in ST_PROBE one slot a cycle (the registered read of the slot
// memories feeds each step), and hands the result to the output register from
// ST_DONE, which holds while the output register stays stalled. The probed
// slots run from 1 up to the table size with load. An unused operation code
// goes straight to ST_DONE and answers not found.
// Requests are taken while an earlier result still waits in the output
// register. Write table_size only while the core is idle.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core import oaht_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [SIZE_W-1:0] cfg_wr_data,
  // request channel
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [1:0]        kind,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [VAL_W-1:0]  value,
  // response channel
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic [1:0]             status,
  output logic [SLOT_W-1:0]      slot,
  output logic [VAL_W-1:0]       found_value
);

  state_t            state;
  state_t            state_next;
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] size_eff;
  logic [SLOT_W-1:0] clr_idx;

  // operation in flight
  kind_t             op_kind;
  logic [KEY_W-1:0]  op_key;
  logic [VAL_W-1:0]  op_value;
  logic [SIZE_W-1:0] op_size;
  logic [SLOT_W-1:0] h;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] hn;

  // pending result
  res_t              res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [VAL_W-1:0]  res_value;

  // memories
  slot_st_t          status_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  key_mem    [TABLE_DEPTH];
  logic [VAL_W-1:0]  value_mem  [TABLE_DEPTH];
  slot_st_t          status_rd;
  logic [KEY_W-1:0]  key_rd;
  logic [VAL_W-1:0]  value_rd;
  logic [SLOT_W-1:0] rd_addr;
  logic              st_we;
  logic [SLOT_W-1:0] st_wa;
  slot_st_t          st_wd;
  logic              dat_we;

  // probe decision
  logic              key_match;
  logic              wrapped;
  logic              pr_done;
  logic              pr_write;
  res_t              pr_status;
  logic [SLOT_W-1:0] pr_slot;
  logic [VAL_W-1:0]  pr_value;

  logic              accept;
  logic              out_free;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  // Clamp the configured size to 1..TABLE_DEPTH
  always_comb begin
    if (table_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (table_size > SIZE_W'(TABLE_DEPTH)) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = table_size;
    end
  end

  // Home slot: key mod size
  oaht_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Slot state memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[st_wa] <= st_wd;
    end
    status_rd <= status_mem[rd_addr];
  end

  // Key and value memory
  always_ff @(posedge clk) begin
    if (dat_we) begin
      key_mem[h]   <= op_key;
      value_mem[h] <= op_value;
    end
    key_rd   <= key_mem[rd_addr];
    value_rd <= value_mem[rd_addr];
  end

  // Judge the slot just read and find the next one in the chain
  always_comb begin
    key_match = key_rd == op_key;
    hn        = (({1'b0, h} + SIZE_W'(1)) == op_size) ? '0 : h + 1'b1;
    wrapped   = hn == home;
    pr_done   = 1'b0;
    pr_write  = 1'b0;
    pr_status = RES_MISS;
    pr_slot   = '0;
    pr_value  = '0;
    case (op_kind)
      KIND_INSERT: begin
        if (status_rd != SLOT_USED || key_match) begin
          pr_done   = 1'b1;
          pr_write  = 1'b1;
          pr_status = RES_OK;
          pr_slot   = h;
        end else if (wrapped) begin
          pr_done   = 1'b1;
          pr_status = RES_FULL;
        end
      end
      KIND_SEARCH, KIND_REMOVE: begin
        if (status_rd == SLOT_FREE) begin
          pr_done = 1'b1;
        end else if (status_rd == SLOT_USED && key_match) begin
          pr_done   = 1'b1;
          pr_write  = op_kind == KIND_REMOVE;
          pr_status = RES_OK;
          pr_slot   = h;
          pr_value  = (op_kind == KIND_SEARCH) ? value_rd : '0;
        end else if (wrapped) begin
          pr_done = 1'b1;
        end
      end
      default: begin
        pr_done = 1'b1;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(kind))
            KIND_INSERT, KIND_SEARCH, KIND_REMOVE: state_next = ST_HASH;
            default:                               state_next = ST_DONE;
          endcase
        end
      end
      ST_HASH: begin
        if (mod_rsp.done) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (pr_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // State outputs: stall, modulo request, memory addresses and writes
  always_comb begin
    req_stall        = 1'b1;
    mod_req.start    = 1'b0;
    mod_req.dividend = key;
    mod_req.divisor  = size_eff;
    rd_addr          = hn;
    st_we            = 1'b0;
    st_wa            = h;
    st_wd            = SLOT_USED;
    dat_we           = 1'b0;
    case (state)
      ST_CLEAR: begin
        st_we = 1'b1;
        st_wa = clr_idx;
        st_wd = SLOT_FREE;
      end
      ST_IDLE: begin
        req_stall     = 1'b0;
        mod_req.start = req_valid;
      end
      ST_HASH: begin
        rd_addr = mod_rsp.rem;
      end
      ST_PROBE: begin
        if (pr_done && pr_write) begin
          st_we  = 1'b1;
          st_wd  = (op_kind == KIND_REMOVE) ? SLOT_GONE : SLOT_USED;
          dat_we = op_kind == KIND_INSERT;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      table_size <= SIZE_W'(TABLE_DEPTH);
      clr_idx    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the request, walk the chain, hold the result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= kind_t'(kind);
      op_key     <= key;
      op_value   <= value;
      op_size    <= size_eff;
      res_status <= RES_MISS;
      res_slot   <= '0;
      res_value  <= '0;
    end
    if (state == ST_HASH && mod_rsp.done) begin
      h    <= mod_rsp.rem;
      home <= mod_rsp.rem;
    end
    if (state == ST_PROBE) begin
      if (pr_done) begin
        res_status <= pr_status;
        res_slot   <= pr_slot;
        res_value  <= pr_value;
      end else begin
        h <= hn;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status      <= res_status;
      slot        <= res_slot;
      found_value <= res_value;
    end
  end

  // Checks
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != RES_OK |-> slot == '0 && found_value == '0)
    else $error("nonzero slot or value on a failed result");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE |-> {1'b0, h} < op_size && {1'b0, home} < op_size)
    else $error("probe outside the table");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_HASH && mod_rsp.done |-> {1'b0, mod_rsp.rem} < op_size)
    else $error("home slot not below table size");

  a_data_write: assert property (@(posedge clk) disable iff (rst)
    dat_we |-> op_kind == KIND_INSERT && st_we && st_wd == SLOT_USED)
    else $error("key write without an insert");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    st_we |-> state == ST_CLEAR || (state == ST_PROBE && pr_done))
    else $error("slot state written outside clear or probe end");

endmodule
`default_nettype wire
